@@ rtl/core/blu2x_pkg.sv @@
// shared constants, types and channel averaging functions for the 2x bilinear upscaler
// no dependencies

package blu2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WCNT_W     = COL_W + 1;
    localparam int HCNT_W     = ROW_W + 1;
    localparam int SIZE_W     = 11;
    localparam int COORD_W    = 11;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int NSLOT      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    typedef logic [NCHAN*CHAN_W-1:0] t_pixel;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_pixel             cur;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last_row;
        logic               last_col;
    } t_stage;

    function automatic t_pixel mean2(t_pixel a, t_pixel b);
        logic [CHAN_W:0] s;
        t_pixel          r;
        r = '0;
        for (int k = 0; k < NCHAN; k++) begin
            s = {1'b0, a[k*CHAN_W +: CHAN_W]} + {1'b0, b[k*CHAN_W +: CHAN_W]}
                + (CHAN_W+1)'(1);
            r[k*CHAN_W +: CHAN_W] = s[CHAN_W:1];
        end
        return r;
    endfunction

    function automatic t_pixel mean4(t_pixel a, t_pixel b, t_pixel c, t_pixel d);
        logic [CHAN_W+1:0] s;
        t_pixel            r;
        r = '0;
        for (int k = 0; k < NCHAN; k++) begin
            s = {2'b00, a[k*CHAN_W +: CHAN_W]} + {2'b00, b[k*CHAN_W +: CHAN_W]}
                + {2'b00, c[k*CHAN_W +: CHAN_W]} + {2'b00, d[k*CHAN_W +: CHAN_W]}
                + (CHAN_W+2)'(2);
            r[k*CHAN_W +: CHAN_W] = s[CHAN_W+1:2];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/blu2x_if.sv @@
// valid/ready channel interfaces: source pixels, result pixels, configuration writes
// depends on blu2x_pkg

interface blu2x_pix_if;
    logic                          valid;
    logic                          ready;
    logic [blu2x_pkg::CHAN_W-1:0]  red_in;
    logic [blu2x_pkg::CHAN_W-1:0]  green_in;
    logic [blu2x_pkg::CHAN_W-1:0]  blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface blu2x_res_if;
    logic                          valid;
    logic                          ready;
    logic [blu2x_pkg::COORD_W-1:0] dest_row;
    logic [blu2x_pkg::COORD_W-1:0] dest_col;
    logic [blu2x_pkg::CHAN_W-1:0]  red_out;
    logic [blu2x_pkg::CHAN_W-1:0]  green_out;
    logic [blu2x_pkg::CHAN_W-1:0]  blue_out;
    logic                          last_of_run;

    modport source (output valid, dest_row, dest_col, red_out, green_out, blue_out,
                    last_of_run, input ready);
    modport sink   (input valid, dest_row, dest_col, red_out, green_out, blue_out,
                    last_of_run, output ready);
endinterface

interface blu2x_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [blu2x_pkg::CFG_IDX_W-1:0] index;
    logic [blu2x_pkg::SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/blu2x_line_mem.sv @@
// one-row line buffer, single port, read-first, registered read data
// depends on blu2x_pkg

module blu2x_line_mem (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [blu2x_pkg::COL_W-1:0]   i_addr,
    input  blu2x_pkg::t_pixel             i_wdata,
    output blu2x_pkg::t_pixel             o_rdata
);

    blu2x_pkg::t_pixel r_mem [blu2x_pkg::MAX_WIDTH];
    blu2x_pkg::t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_addr] <= i_wdata;
            r_rdata       <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/blu2x_fetch.sv @@
// input side: size registers, source position counters, line buffer access, first stage
// depends on blu2x_pkg, blu2x_if

module blu2x_fetch (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blu2x_cfg_if.sink                     i_cfg,
    blu2x_pix_if.sink                     i_pix,
    input  logic                          i_take,
    output logic                          o_s1_vld,
    output blu2x_pkg::t_stage             o_s1,
    output logic                          o_mem_en,
    output logic [blu2x_pkg::COL_W-1:0]   o_mem_addr,
    output blu2x_pkg::t_pixel             o_mem_wdata
);

    logic [blu2x_pkg::WCNT_W-1:0] r_w, n_w;
    logic [blu2x_pkg::HCNT_W-1:0] r_h, n_h;
    logic [blu2x_pkg::COL_W-1:0]  r_col;
    logic [blu2x_pkg::ROW_W-1:0]  r_row;
    logic                         r_s1_vld;
    blu2x_pkg::t_stage            r_s1;

    logic                         wrap_col;
    logic [blu2x_pkg::HCNT_W-1:0] row_t;
    logic [blu2x_pkg::ROW_W-1:0]  row_c;
    logic [blu2x_pkg::COL_W-1:0]  col_c;
    logic                         last_col, last_row;
    logic                         accept;
    blu2x_pkg::t_pixel            pix;

    // clamp written sizes to 1..max
    always_comb begin
        if (i_cfg.data == '0) begin
            n_w = blu2x_pkg::WCNT_W'(1);
        end else if (32'(i_cfg.data) > blu2x_pkg::MAX_WIDTH) begin
            n_w = blu2x_pkg::WCNT_W'(blu2x_pkg::MAX_WIDTH);
        end else begin
            n_w = blu2x_pkg::WCNT_W'(i_cfg.data);
        end
        if (i_cfg.data == '0) begin
            n_h = blu2x_pkg::HCNT_W'(1);
        end else if (32'(i_cfg.data) > blu2x_pkg::MAX_HEIGHT) begin
            n_h = blu2x_pkg::HCNT_W'(blu2x_pkg::MAX_HEIGHT);
        end else begin
            n_h = blu2x_pkg::HCNT_W'(i_cfg.data);
        end
    end

    // position of this item, wrapped against sizes changed mid-frame
    always_comb begin
        wrap_col = {1'b0, r_col} >= r_w;
        row_t    = wrap_col ? {1'b0, r_row} + blu2x_pkg::HCNT_W'(1) : {1'b0, r_row};
        row_c    = (row_t >= r_h) ? '0 : row_t[blu2x_pkg::ROW_W-1:0];
        col_c    = wrap_col ? '0 : r_col;
        last_col = {1'b0, col_c} == r_w - blu2x_pkg::WCNT_W'(1);
        last_row = {1'b0, row_c} == r_h - blu2x_pkg::HCNT_W'(1);
    end

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_s1_vld || i_take;
    assign accept      = i_pix.valid && i_pix.ready;
    assign pix         = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= blu2x_pkg::WCNT_W'(blu2x_pkg::WIDTH_RST);
            r_h      <= blu2x_pkg::HCNT_W'(blu2x_pkg::HEIGHT_RST);
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == blu2x_pkg::REG_WIDTH) begin
                    r_w <= n_w;
                end else begin
                    r_h <= n_h;
                end
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
                r_col    <= last_col ? '0 : col_c + blu2x_pkg::COL_W'(1);
                if (last_col) begin
                    r_row <= last_row ? '0 : row_c + blu2x_pkg::ROW_W'(1);
                end else begin
                    r_row <= row_c;
                end
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.cur      <= pix;
            r_s1.row      <= row_c;
            r_s1.col      <= col_c;
            r_s1.last_row <= last_row;
            r_s1.last_col <= last_col;
        end
    end

    assign o_s1_vld    = r_s1_vld;
    assign o_s1        = r_s1;
    assign o_mem_en    = accept;
    assign o_mem_addr  = col_c;
    assign o_mem_wdata = pix;

endmodule

@@ rtl/core/blu2x_emit.sv @@
// result side: neighbor window, destination slot sequencer, interpolation, output register
// depends on blu2x_pkg, blu2x_if

module blu2x_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s1_vld,
    input  blu2x_pkg::t_stage    i_s1,
    input  blu2x_pkg::t_pixel    i_above,
    output logic                 o_take,
    blu2x_res_if.source          o_res
);

    logic                              r_busy;
    logic [blu2x_pkg::NSLOT-1:0]       r_mask;
    blu2x_pkg::t_pixel                 r_cur, r_above, r_left, r_abl;
    logic [blu2x_pkg::ROW_W-1:0]       r_row;
    logic [blu2x_pkg::COL_W-1:0]       r_col;

    logic                              r_out_vld;
    logic [blu2x_pkg::COORD_W-1:0]     r_out_row, r_out_col;
    blu2x_pkg::t_pixel                 r_out_pix;
    logic                              r_out_last;

    logic [blu2x_pkg::NSLOT-1:0]       onehot, rest, n_mask;
    logic [1:0]                        rsel, csel;
    logic [2:0]                        en_row, en_col;
    logic                              can_out, fire, last_slot;
    blu2x_pkg::t_pixel                 val;
    logic [blu2x_pkg::COORD_W-1:0]     drow, dcol;

    always_comb begin
        onehot = r_mask & (~r_mask + blu2x_pkg::NSLOT'(1));
        rest   = r_mask & ~onehot;
        rsel   = '0;
        csel   = '0;
        for (int i = 0; i < blu2x_pkg::NSLOT; i++) begin
            if (onehot[i]) begin
                rsel = 2'(i / 3);
                csel = 2'(i % 3);
            end
        end
    end

    // slots in raster order: rows above/center/below, columns left/center/right
    always_comb begin
        if (rsel == 2'd0) begin
            val = (csel == 2'd0) ? blu2x_pkg::mean4(r_abl, r_above, r_left, r_cur)
                                 : blu2x_pkg::mean2(r_above, r_cur);
        end else begin
            val = (csel == 2'd0) ? blu2x_pkg::mean2(r_left, r_cur) : r_cur;
        end
        drow = blu2x_pkg::COORD_W'({r_row, 1'b0}) + blu2x_pkg::COORD_W'(rsel)
               - blu2x_pkg::COORD_W'(1);
        dcol = blu2x_pkg::COORD_W'({r_col, 1'b0}) + blu2x_pkg::COORD_W'(csel)
               - blu2x_pkg::COORD_W'(1);
    end

    always_comb begin
        en_row = {i_s1.last_row, 1'b1, i_s1.row != '0};
        en_col = {i_s1.last_col, 1'b1, i_s1.col != '0};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_mask[i*3+j] = en_row[i] & en_col[j];
            end
        end
    end

    assign can_out   = !r_out_vld || o_res.ready;
    assign fire      = r_busy && can_out;
    assign last_slot = rest == '0;
    assign o_take    = i_s1_vld && (!r_busy || (fire && last_slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
            r_mask    <= '0;
            r_cur     <= '0;
            r_above   <= '0;
            r_left    <= '0;
            r_abl     <= '0;
        end else begin
            if (fire) begin
                r_out_vld <= 1'b1;
                r_mask    <= rest;
                if (last_slot) begin
                    r_busy <= 1'b0;
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (o_take) begin
                r_busy  <= 1'b1;
                r_mask  <= n_mask;
                r_left  <= r_cur;
                r_abl   <= r_above;
                r_cur   <= i_s1.cur;
                r_above <= i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_row <= i_s1.row;
            r_col <= i_s1.col;
        end
        if (fire) begin
            r_out_row  <= drow;
            r_out_col  <= dcol;
            r_out_pix  <= val;
            r_out_last <= last_slot;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.dest_row    = r_out_row;
    assign o_res.dest_col    = r_out_col;
    assign o_res.red_out     = r_out_pix[3*blu2x_pkg::CHAN_W-1:2*blu2x_pkg::CHAN_W];
    assign o_res.green_out   = r_out_pix[2*blu2x_pkg::CHAN_W-1:blu2x_pkg::CHAN_W];
    assign o_res.blue_out    = r_out_pix[blu2x_pkg::CHAN_W-1:0];
    assign o_res.last_of_run = r_out_last;

endmodule

@@ rtl/core/bilinear_upscale_2x.sv @@
// top level of the streaming 2x bilinear upscaler
// depends on blu2x_pkg, blu2x_if, blu2x_line_mem, blu2x_fetch, blu2x_emit
//
// i_pix takes source RGB888 pixels in raster order. o_res gives every destination
// pixel as soon as its source neighbors are in, with its destination row and column,
// in destination raster order per source pixel; last_of_run marks the final result
// of each source pixel. i_cfg writes source_width (index 0) and source_height
// (index 1), clamped to 1..1024; write them only while no item is in flight.
// Each source pixel makes 1 to 9 results, about 4 per item over a frame, one per
// cycle from the result sequencer unless the receiver stalls. An accepted item
// passes the first stage and the neighbor window before its first result is
// registered. The line buffer is one single-port memory, read and written once
// per item at the source column, which lets a new item enter every cycle the
// sequencer frees its window. A stalled receiver holds the result register; one item
// waits in the first stage and the input is refused until the sequencer can move on.
// Reset clears the position counters, the neighbor window and all valid state and
// restores the sizes to 640 by 480; the line buffer needs no clearing, since row
// zero results never use what it reads.

module bilinear_upscale_2x (
    input  logic         i_clk,
    input  logic         i_rst_n,
    blu2x_cfg_if.sink    i_cfg,
    blu2x_pix_if.sink    i_pix,
    blu2x_res_if.source  o_res
);

    logic                          s1_vld;
    blu2x_pkg::t_stage             s1;
    logic                          take;
    logic                          mem_en;
    logic [blu2x_pkg::COL_W-1:0]   mem_addr;
    blu2x_pkg::t_pixel             mem_wdata, mem_rdata;

    blu2x_fetch u_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pix       (i_pix),
        .i_take      (take),
        .o_s1_vld    (s1_vld),
        .o_s1        (s1),
        .o_mem_en    (mem_en),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    blu2x_line_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    blu2x_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1_vld (s1_vld),
        .i_s1     (s1),
        .i_above  (mem_rdata),
        .o_take   (take),
        .o_res    (o_res)
    );

endmodule

@@ rtl/core/blu2x_checker.sv @@
// port-level checks for the upscaler: result handshake and items in flight
// depends on blu2x_pkg; bound to bilinear_upscale_2x

module blu2x_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [blu2x_pkg::COORD_W-1:0] i_dest_row,
    input logic [blu2x_pkg::COORD_W-1:0] i_dest_col,
    input logic                          i_last
);

    logic [2:0] r_pend;
    logic       in_acc, out_end;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_end = i_out_valid && i_out_ready && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(in_acc) - 3'(out_end);
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped under stall");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd3)
        else $error("more items in flight than stages");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 3'd0)
        else $error("result with no item in flight");

    a_coord_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last ##1 i_out_valid |->
        (i_dest_row != $past(i_dest_row) || i_dest_col != $past(i_dest_col)))
        else $error("repeated destination within one item");

endmodule

bind bilinear_upscale_2x blu2x_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_dest_row  (o_res.dest_row),
    .i_dest_col  (o_res.dest_col),
    .i_last      (o_res.last_of_run)
);
